@@ hw/rtl/ljp_pkg.sv @@
// Shared constants for the Lennard-Jones pair energy pipeline.
package ljp_pkg;

  // Fraction bits of coordinates, box and energy (default).
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;

  // Box edge register: width and reset value (14.0 in Q16.16).
  localparam int unsigned BOX_W = 31;
  localparam logic [BOX_W-1:0] BOX_RESET = 31'd917504;

  // r squared below 2^-4 (Q32.32) saturates; this bounds 1/r2 to 36 bits.
  localparam int unsigned Q_MIN_LOG2 = 28;
  localparam int unsigned DIV_QW = 64 - Q_MIN_LOG2;

  // Widths of 1/r2, its square, its cube and the cube squared (Q32.32).
  localparam int unsigned S_W = DIV_QW;
  localparam int unsigned P_W = 40;
  localparam int unsigned T_W = 44;
  localparam int unsigned U_W = 56;

  // Largest positive energy code.
  localparam logic [31:0] ENERGY_MAX = 32'h7FFF_FFFF;

endpackage

@@ hw/rtl/ljp_div.sv @@
// Pipelined restoring divider: all-ones dividend over a 64-bit divisor, one quotient bit a stage.
module ljp_div #(
  parameter int unsigned QW = ljp_pkg::DIV_QW,
  parameter int unsigned DW = 64,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // Upper dividend bits that sit below the divisor before the first step.
  localparam logic [DW-1:0] REM_INIT = {DW{1'b1}} >> QW;

  logic [DW-1:0] rem_w  [QW+1];
  logic [DW-1:0] den_w  [QW+1];
  logic [QW-1:0] quo_w  [QW+1];
  logic          vld_w  [QW+1];
  logic [SW-1:0] side_w [QW+1];

  assign rem_w[0]  = REM_INIT;
  assign den_w[0]  = den_i;
  assign quo_w[0]  = '0;
  assign vld_w[0]  = vld_i;
  assign side_w[0] = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_q;
    logic [DW-1:0] den_q;
    logic [QW-1:0] quo_q;
    logic          vld_q;
    logic [SW-1:0] side_q;

    // Bring down the next dividend bit (always one) and try the subtract.
    assign trial = {rem_w[i], 1'b1};
    assign ge    = trial >= {1'b0, den_w[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? DW'(trial - {1'b0, den_w[i]}) : trial[DW-1:0];
        den_q  <= den_w[i];
        quo_q  <= {quo_w[i][QW-2:0], ge};
        side_q <= side_w[i];
      end
    end

    assign rem_w[i+1]  = rem_q;
    assign den_w[i+1]  = den_q;
    assign quo_w[i+1]  = quo_q;
    assign vld_w[i+1]  = vld_q;
    assign side_w[i+1] = side_q;
  end

  assign vld_o  = vld_w[QW];
  assign quo_o  = quo_w[QW];
  assign side_o = side_w[QW];

endmodule

@@ hw/rtl/ljp_mul.sv @@
// Two-stage Q32.32 multiplier built from 32-bit partial products, rounded half up.
module ljp_mul #(
  parameter int unsigned AW = 36,
  parameter int unsigned BW = 36,
  parameter int unsigned PW = 40,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [PW-1:0] prod_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned AH = AW - 32;
  localparam int unsigned BH = BW - 32;
  localparam int unsigned FW = AW + BW;

  logic [63:0]      ll_q;
  logic [AH+31:0]   hl_q;
  logic [BH+31:0]   lh_q;
  logic [AH+BH-1:0] hh_q;
  logic             vld1_q;
  logic [SW-1:0]    side1_q;
  logic [FW-1:0]    full;
  logic [PW-1:0]    prod_q;
  logic             vld2_q;
  logic [SW-1:0]    side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  // Form the partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      hl_q    <= (AH+32)'(a_i[AW-1:32]) * (AH+32)'(b_i[31:0]);
      lh_q    <= (BH+32)'(a_i[31:0]) * (BH+32)'(b_i[BW-1:32]);
      hh_q    <= (AH+BH)'(a_i[AW-1:32]) * (AH+BH)'(b_i[BW-1:32]);
      side1_q <= side_i;
    end
  end

  // Sum the partials, add the rounding half and drop 32 fraction bits.
  assign full = FW'(ll_q) + (FW'(hl_q) << 32) + (FW'(lh_q) << 32) + (FW'(hh_q) << 64)
              + FW'(64'h8000_0000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= full[PW+31:32];
      side2_q <= side1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign prod_o = prod_q;
  assign side_o = side2_q;

endmodule

@@ hw/rtl/lj_pair_energy_min_image_core.sv @@
// Top level: Lennard-Jones 12-6 pair energy with minimum-image wrap, fully pipelined.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid_i / in_ready_o   | first_{x,y,z}_i, second_{x,y,z}_i
//  output   | out_valid_o / out_ready_i | pair_energy_o, saturated_o
//  config   | cfg_wr_en_i               | cfg_wr_data_i (box edge, Q16.16)
//
// One item enters per cycle unless the pipe stalls. Five front stages (difference, wrap,
// square, sum, scale), 36 divider stages (one bit of 1/r2 each), three two-stage
// multipliers and two output stages make up the pipe; the whole pipe advances together
// whenever the output register is empty or being taken, so a stall holds every stage in
// place. Reset clears the valid bits and loads the box edge with 14.0.
module lj_pair_energy_min_image_core #(
  parameter int unsigned COORD_FRAC_BITS = ljp_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [ljp_pkg::BOX_W-1:0] cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [31:0]        first_x_i,
  input  logic signed [31:0]        first_y_i,
  input  logic signed [31:0]        first_z_i,
  input  logic signed [31:0]        second_x_i,
  input  logic signed [31:0]        second_y_i,
  input  logic signed [31:0]        second_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        pair_energy_o,
  output logic                      saturated_o
);

  localparam int unsigned FB = 2 * COORD_FRAC_BITS;
  localparam int unsigned MS = 30 - COORD_FRAC_BITS;
  localparam int unsigned RB = 29 - COORD_FRAC_BITS;
  localparam int unsigned MW = ljp_pkg::U_W + 1;
  localparam int unsigned BW = ljp_pkg::BOX_W;

  logic          en;
  logic [BW-1:0] box_q;

  // Global advance: move when the output slot is free or being taken.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Box edge register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= ljp_pkg::BOX_RESET;
    end else if (cfg_wr_en_i) begin
      box_q <= cfg_wr_data_i;
    end
  end

  // ---------------- stage 1: raw difference and absolute coordinates
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [32:0] d1_d  [3];
  logic        [32:0] ad1_d [3];
  logic        [32:0] sab1_d [3];
  logic signed [32:0] d1_q  [3];
  logic        [32:0] ad1_q [3];
  logic        [32:0] sab1_q [3];
  logic               vld1_q;

  assign pa[0] = first_x_i;
  assign pa[1] = first_y_i;
  assign pa[2] = first_z_i;
  assign pb[0] = second_x_i;
  assign pb[1] = second_y_i;
  assign pb[2] = second_z_i;

  always_comb begin
    logic [32:0] aa;
    logic [32:0] ab;
    for (int k = 0; k < 3; k++) begin
      d1_d[k]   = {pa[k][31], pa[k]} - {pb[k][31], pb[k]};
      ad1_d[k]  = d1_d[k][32] ? 33'(-d1_d[k]) : 33'(d1_d[k]);
      aa        = pa[k][31] ? 33'(-{1'b1, pa[k]}) : {1'b0, pa[k]};
      ab        = pb[k][31] ? 33'(-{1'b1, pb[k]}) : {1'b0, pb[k]};
      sab1_d[k] = aa + ab;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= d1_d;
      ad1_q  <= ad1_d;
      sab1_q <= sab1_d;
    end
  end

  // ---------------- stage 2: minimum-image wrap, absolute value, range cap
  logic [30:0] ad2_d [3];
  logic [2:0]  cap2_d;
  logic [30:0] ad2_q [3];
  logic        cap2_q;
  logic        vld2_q;

  always_comb begin
    logic               wrap;
    logic signed [33:0] dm;
    logic        [33:0] adm;
    for (int k = 0; k < 3; k++) begin
      wrap      = {ad1_q[k], 1'b0} > {3'b000, box_q};
      dm        = wrap ? $signed({3'b000, box_q} - {1'b0, sab1_q[k]})
                       : $signed({d1_q[k][32], d1_q[k]});
      adm       = dm[33] ? 34'(-dm) : 34'(dm);
      cap2_d[k] = adm[33:31] != 3'b000;
      ad2_d[k]  = adm[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ad2_q  <= ad2_d;
      cap2_q <= |cap2_d;
    end
  end

  // ---------------- stage 3: square each axis
  logic [61:0] sq3_q [3];
  logic        cap3_q;
  logic        vld3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq3_q[k] <= 62'(ad2_q[k]) * 62'(ad2_q[k]);
      end
      cap3_q <= cap2_q;
    end
  end

  // ---------------- stage 4: sum into r squared
  logic [63:0] r4_q;
  logic        cap4_q;
  logic        vld4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r4_q   <= 64'(sq3_q[0]) + 64'(sq3_q[1]) + 64'(sq3_q[2]);
      cap4_q <= cap3_q;
    end
  end

  // ---------------- stage 5: clamp, rescale to Q32.32, flag short distances
  localparam logic [63:0] R2_CAP = 64'h8000_0000_0000_0000;

  logic [63:0] rc5;
  logic [63:0] q5_d;
  logic        flag5_d;
  logic [63:0] q5_q;
  logic        flag5_q;
  logic        vld5_q;

  assign rc5 = (cap4_q || r4_q > R2_CAP) ? R2_CAP : r4_q;

  if (FB == 32) begin : g_q_same
    assign q5_d = rc5;
  end else if (FB < 32) begin : g_q_up
    localparam int unsigned SH = 32 - FB;
    assign q5_d = ((rc5 >> (64 - SH)) != 64'd0) ? {64{1'b1}} : (rc5 << SH);
  end else begin : g_q_down
    localparam int unsigned SH = FB - 32;
    assign q5_d = (rc5 >> SH) + 64'(rc5[SH-1]);
  end

  assign flag5_d = (rc5 == 64'd0) || (q5_d[63:ljp_pkg::Q_MIN_LOG2] == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      q5_q    <= q5_d;
      flag5_q <= flag5_d;
    end
  end

  // Front-stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  // ---------------- 1/r2 divider
  logic                    vld_s;
  logic [ljp_pkg::S_W-1:0] s_w;
  logic                    flag_s;

  ljp_div #(
    .QW(ljp_pkg::DIV_QW),
    .DW(64),
    .SW(1)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld5_q),
    .den_i  (q5_q),
    .side_i (flag5_q),
    .vld_o  (vld_s),
    .quo_o  (s_w),
    .side_o (flag_s)
  );

  // ---------------- r^-4, r^-6, r^-12
  logic                    vld_p;
  logic [ljp_pkg::P_W-1:0] p_w;
  logic                    flag_p;
  logic [ljp_pkg::S_W-1:0] s_p;
  logic                    vld_t;
  logic [ljp_pkg::T_W-1:0] t_w;
  logic                    flag_t;
  logic                    vld_u;
  logic [ljp_pkg::U_W-1:0] u_w;
  logic                    flag_u;
  logic [ljp_pkg::T_W-1:0] t_u;

  ljp_mul #(
    .AW(ljp_pkg::S_W),
    .BW(ljp_pkg::S_W),
    .PW(ljp_pkg::P_W),
    .SW(1 + ljp_pkg::S_W)
  ) u_mul_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_s),
    .a_i    (s_w),
    .b_i    (s_w),
    .side_i ({flag_s, s_w}),
    .vld_o  (vld_p),
    .prod_o (p_w),
    .side_o ({flag_p, s_p})
  );

  ljp_mul #(
    .AW(ljp_pkg::P_W),
    .BW(ljp_pkg::S_W),
    .PW(ljp_pkg::T_W),
    .SW(1)
  ) u_mul_cube (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_p),
    .a_i    (p_w),
    .b_i    (s_p),
    .side_i (flag_p),
    .vld_o  (vld_t),
    .prod_o (t_w),
    .side_o (flag_t)
  );

  ljp_mul #(
    .AW(ljp_pkg::T_W),
    .BW(ljp_pkg::T_W),
    .PW(ljp_pkg::U_W),
    .SW(1 + ljp_pkg::T_W)
  ) u_mul_six (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_t),
    .a_i    (t_w),
    .b_i    (t_w),
    .side_i ({flag_t, t_w}),
    .vld_o  (vld_u),
    .prod_o (u_w),
    .side_o ({flag_u, t_u})
  );

  // ---------------- stage F1: signed difference of the two terms
  logic [ljp_pkg::U_W-1:0] diff_q;
  logic                    neg_q;
  logic                    flagf_q;
  logic                    vldf_q;
  logic                    neg_d;

  assign neg_d = u_w < ljp_pkg::U_W'(t_u);

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q  <= neg_d ? ljp_pkg::U_W'(ljp_pkg::U_W'(t_u) - u_w)
                       : ljp_pkg::U_W'(u_w - ljp_pkg::U_W'(t_u));
      neg_q   <= neg_d;
      flagf_q <= flag_u;
    end
  end

  // ---------------- stage F2: scale by four, round, saturate
  logic [MW-1:0] mag;
  logic          ovf;
  logic [31:0]   energy_d;
  logic [31:0]   energy_q;
  logic          sat_q;
  logic          vldo_q;

  assign mag = MW'(diff_q >> MS) + MW'(diff_q[RB]);
  assign ovf = !neg_q && (mag > MW'(ljp_pkg::ENERGY_MAX));

  always_comb begin
    if (flagf_q || ovf) begin
      energy_d = ljp_pkg::ENERGY_MAX;
    end else if (neg_q) begin
      energy_d = 32'(-mag[31:0]);
    end else begin
      energy_d = mag[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      energy_q <= energy_d;
      sat_q    <= flagf_q || ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
      vldo_q <= 1'b0;
    end else if (en) begin
      vldf_q <= vld_u;
      vldo_q <= vldf_q;
    end
  end

  assign out_valid_o   = vldo_q;
  assign pair_energy_o = energy_q;
  assign saturated_o   = sat_q;

  // ---------------- checks
  localparam logic signed [31:0] NEG_ONE = -(32'sd1 <<< COORD_FRAC_BITS);

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> pair_energy_o == ljp_pkg::ENERGY_MAX)
    else $error("saturated result does not hold the largest energy");

  a_energy_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !saturated_o |-> pair_energy_o >= NEG_ONE)
    else $error("energy below the well depth");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vldf_q) && $stable(vld5_q) && $stable(diff_q))
    else $error("pipeline moved during a stall");

endmodule

@@ bench/lj_pair_energy_checker.sv @@
// Energy predictor and result scoreboard for the pair energy core.
module lj_pair_energy_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [ljp_pkg::BOX_W-1:0] cfg_wr_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_o,
  input  logic signed [31:0]        first_x_i,
  input  logic signed [31:0]        first_y_i,
  input  logic signed [31:0]        first_z_i,
  input  logic signed [31:0]        second_x_i,
  input  logic signed [31:0]        second_y_i,
  input  logic signed [31:0]        second_z_i,
  input  logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic signed [31:0]        pair_energy_o,
  input  logic                      saturated_o,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        sat_seen_o,
  output int                        neg_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;

  typedef struct packed {
    logic [31:0] energy;
    logic        sat;
  } energy_t;

  logic [30:0] box_q;
  energy_t     energy_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = energy_q.size();

  // Q32.32 product rounded half up, saturating at all ones.
  function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b + 128'h8000_0000;
    p = p >> 32;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  // Minimum-image difference of one axis.
  function automatic longint wrap_diff(longint a, longint b, longint box);
    longint d, ad;
    d  = a - b;
    ad = d < 0 ? -d : d;
    if (2 * ad > box) d = box - (a < 0 ? -a : a) - (b < 0 ? -b : b);
    return d;
  endfunction

  function automatic energy_t lj_energy(logic signed [31:0] c[6], logic [30:0] box);
    logic [64:0]  r2;
    logic [63:0]  q, s, t, u, diff, mag;
    logic         capped, neg;
    longint       d;
    logic [63:0]  ad;
    energy_t      res;
    r2 = 0;
    capped = 0;
    for (int i = 0; i < 3; i++) begin
      d  = wrap_diff(longint'(c[i]), longint'(c[i+3]), longint'(box));
      ad = d < 0 ? -d : d;
      if (ad >= 64'h8000_0000) capped = 1;
      else r2 += ad * ad;
    end
    if (capped || r2 > 65'h8000_0000_0000_0000) r2 = 65'h8000_0000_0000_0000;
    res.energy = 32'h7FFF_FFFF;
    res.sat = 1;
    if (r2 == 0) return res;
    q = r2[63:0];
    if (q < 64'h1000_0000) return res;
    s = 64'hFFFF_FFFF_FFFF_FFFF / q;
    t = q32_mul(q32_mul(s, s), s);
    u = q32_mul(t, t);
    neg  = u < t;
    diff = neg ? t - u : u - t;
    mag  = (diff >> (30 - FRAC)) + ((diff >> (29 - FRAC)) & 64'd1);
    if (!neg && mag > 64'h7FFF_FFFF) return res;
    res.energy = neg ? 32'(-mag) : mag[31:0];
    res.sat = 0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // Track box, predict on accepted items, compare on accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] c[6];
    energy_t exp_e;
    if (!rst_ni) begin
      box_q <= ljp_pkg::BOX_RESET;
      energy_q.delete();
      fails = 0;
      sat_seen_o = 0;
      neg_seen_o = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        c = '{first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i};
        energy_q.push_back(lj_energy(c, box_q));
      end
      if (out_valid_o && out_ready_i) begin
        if (energy_q.size() == 0) begin
          report_mismatch("unexpected item", pair_energy_o, 0);
        end else begin
          exp_e = energy_q.pop_front();
          if (pair_energy_o !== exp_e.energy)
            report_mismatch("pair_energy", pair_energy_o, exp_e.energy);
          if (saturated_o !== exp_e.sat)
            report_mismatch("saturated", saturated_o, exp_e.sat);
          if (exp_e.sat) sat_seen_o++;
          if (exp_e.energy[31]) neg_seen_o++;
        end
      end
      if (cfg_wr_en_i) box_q <= cfg_wr_data_i;
    end
  end
endmodule

@@ bench/lj_pair_energy_min_image_core_tb.sv @@
// Stimulus and verdict for the Lennard-Jones pair energy core.
module lj_pair_energy_min_image_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 49;
  localparam int LIMIT_CYC = 400000;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_wr_en_i = 0;
  logic [30:0] cfg_wr_data_i = '0;
  logic in_valid_i = 0, out_ready_i = 0;
  logic in_ready_o, out_valid_o, saturated_o;
  logic signed [31:0] first_x_i = 0, first_y_i = 0, first_z_i = 0;
  logic signed [31:0] second_x_i = 0, second_y_i = 0, second_z_i = 0;
  logic signed [31:0] pair_energy_o;
  int fail_count, pending, sat_seen, neg_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  int cycles = 0, item_count = 0;

  always #1 clk_i = ~clk_i;

  lj_pair_energy_min_image_core i_dut (.*);
  lj_pair_energy_checker i_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending),
    .sat_seen_o(sat_seen), .neg_seen_o(neg_seen)
  );

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall pattern, held off entirely during a long stretch.
  always @(negedge clk_i)
    out_ready_i <= rst_ni && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  // Keep valid up into the next item; idle cycles and a drain drop it.
  task automatic send_pair(logic signed [31:0] fx, fy, fz, sx, sy, sz);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    {first_x_i, first_y_i, first_z_i} <= {fx, fy, fz};
    {second_x_i, second_y_i, second_z_i} <= {sx, sy, sz};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    item_count++;
  endtask

  task automatic drain_pipe();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_box(logic [30:0] val);
    drain_pipe();
    cfg_wr_en_i <= 1;
    cfg_wr_data_i <= val;
    @(negedge clk_i);
    cfg_wr_en_i <= 0;
  endtask

  // Coordinate near the box scale, occasionally anything.
  function automatic logic signed [31:0] rand_coord(logic [30:0] box);
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return $urandom;
    if (k == 1) return $signed($urandom_range(131072)) - 65536;
    return $signed(32'($urandom_range(box))) - $signed(32'(box >> 1));
  endfunction

  task automatic random_pairs(int n, logic [30:0] box);
    logic signed [31:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      a = rand_coord(box); b = rand_coord(box); c = rand_coord(box);
      // Close pairs exercise the repulsive and saturating region.
      if ($urandom_range(3) == 0)
        send_pair(a, b, c, a + $signed($urandom_range(131072)) - 65536,
                  b + $signed($urandom_range(65536)), c - $signed($urandom_range(65536)));
      else
        send_pair(a, b, c, rand_coord(box), rand_coord(box), rand_coord(box));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: zero distance, tiny, near minimum, far, extremes, wrap.
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 32'sd1000, 0, 0);
    send_pair(0, 0, 0, 32'sd73562, 0, 0);
    send_pair(0, 0, 0, 32'sd65536, 0, 0);
    send_pair(0, 0, 0, 32'sd131072, 0, 0);
    send_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_pair(32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh7FFFFFFF);
    send_pair(-32'sd450000, 0, 0, 32'sd450000, 0, 0);
    send_pair(32'sd393216, 32'sd393216, -32'sd393216, -32'sd393216, -32'sd393216,
              32'sd393216);
    send_pair(32'shFFFFFFFF, 32'shAAAAAAAA, 32'sh55555555, 0, 32'sh55555555, 32'shAAAAAAAA);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 9; recv_idle_pct = 60;
    random_pairs(200, ljp_pkg::BOX_RESET);

    // Long receiver hold-off while items keep coming.
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk_i);
        hold_off = 0;
      end
      random_pairs(80, ljp_pkg::BOX_RESET);
    join

    // Pause until every result is back, then change the box.
    write_box('0);
    send_idle_pct = 60; recv_idle_pct = 9;
    random_pairs(60, 31'd0);
    write_box(31'h7FFFFFFF);
    random_pairs(60, 31'h7FFFFFFF);
    write_box(31'd196608);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_pairs(150, 31'd196608);
    write_box(31'd1310720);
    random_pairs(100, 31'd1310720);

    drain_pipe();
    $display("sent %0d pairs over five box settings incl. 0 and max, with stalls",
             item_count);
    $display("saturated results %0d, negative energies %0d", sat_seen, neg_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ lj_pair_energy_min_image_core.f @@
hw/rtl/ljp_pkg.sv
hw/rtl/ljp_div.sv
hw/rtl/ljp_mul.sv
hw/rtl/lj_pair_energy_min_image_core.sv
bench/lj_pair_energy_checker.sv
bench/lj_pair_energy_min_image_core_tb.sv
